/* rtl/core/sre_pkg.sv */
`default_nettype none

package sre_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_REVOLUTIONS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAST_BAND_RPM   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAST_TIMEOUT_US = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MID_BAND_RPM    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MID_TIMEOUT_US  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOW_TIMEOUT_US = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MOVING_RPM      = 3'd6;

   localparam logic [7:0]  RST_MIN_REVOLUTIONS = 8'd4;
   localparam logic [15:0] RST_FAST_BAND_RPM   = 16'd600;
   localparam logic [31:0] RST_FAST_TIMEOUT_US = 32'd500000;
   localparam logic [15:0] RST_MID_BAND_RPM    = 16'd200;
   localparam logic [31:0] RST_MID_TIMEOUT_US  = 32'd2000000;
   localparam logic [31:0] RST_SLOW_TIMEOUT_US = 32'd5000000;
   localparam logic [15:0] RST_MOVING_RPM      = 16'd10;

   localparam logic [1:0] DIR_IDLE = 2'd0;
   localparam logic [1:0] DIR_CW   = 2'd1;
   localparam logic [1:0] DIR_CCW  = 2'd2;

   // 0.4 * 60e6 scaled by 5 in the denominator
   localparam logic [26:0] SCALE_NUM = 27'd120000000;

   // ceil(2^34 / 5): (x * RECIP_FIVE) >> 34 is x / 5 for any 32-bit x
   localparam logic [31:0] RECIP_FIVE = 32'hCCCC_CCCD;

   localparam int unsigned DIV_WIDTH      = 64;
   localparam int unsigned DIV_STEP_WIDTH = 7;
   localparam logic [DIV_STEP_WIDTH-1:0] Q1_STEPS = 7'd62;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CALC,
      ST_SPLIT,
      ST_PREP,
      ST_LOAD_Q1,
      ST_WAIT_Q1,
      ST_SUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [7:0]  min_revolutions;
      logic [15:0] fast_band_rpm;
      logic [31:0] fast_timeout_us;
      logic [15:0] mid_band_rpm;
      logic [31:0] mid_timeout_us;
      logic [31:0] slow_timeout_us;
      logic [15:0] moving_rpm;
   } cfg_type;

   typedef struct packed {
      logic                      start;
      logic [DIV_STEP_WIDTH-1:0] steps;
   } div_cmd_type;

endpackage

`default_nettype wire

/* rtl/core/sre_if.sv */
`default_nettype none

interface sre_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] revolution_count;
   logic [63:0] time_us;
   logic        counting_down;

   modport source (output valid, output revolution_count, output time_us,
                   output counting_down, input ready);
   modport sink (input valid, input revolution_count, input time_us,
                 input counting_down, output ready);
endinterface

interface sre_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] speed_rpm;
   logic [1:0]  turn_direction;
   logic        recomputed;

   modport source (output valid, output speed_rpm, output turn_direction,
                   output recomputed, input ready);
   modport sink (input valid, input speed_rpm, input turn_direction,
                 input recomputed, output ready);
endinterface

`default_nettype wire

/* rtl/core/spindle_rpm_estimator_unit.sv */
`default_nettype none

// From accept to result, a recomputed speed passes CALC, SPLIT, PREP, LOAD_Q1, WAIT_Q1
// (one 62-step pass of the one-bit-a-cycle divider), SUM and FINISH; PREP goes to SUM when
// the division is skipped because the elapsed time exceeds the scaled delta, CALC to FINISH
// otherwise. Throughput: one update at a time, the next accepted in the cycle after the
// result is registered; a result still waiting in the output register holds it.
// Synchronous active-high reset restores register defaults, clears speed, count, time, direction.
module spindle_rpm_estimator_unit import sre_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   sre_req_if.sink                    req,
   sre_rsp_if.source                  rsp,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type cfg;

   sre_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   state_type state_ff;
   state_type state_in;

   div_cmd_type          div_cmd;
   logic [DIV_WIDTH-1:0] div_num;
   logic [DIV_WIDTH-1:0] div_den;
   logic                 div_done;
   logic [DIV_WIDTH-1:0] div_quo;

   // item in work
   logic [31:0] count_ff;
   logic [63:0] now_ff;
   logic        down_ff;
   logic [31:0] delta_ff;
   logic [63:0] elapsed_ff;
   logic        recomp_ff;
   logic [58:0] a_ff;
   logic [63:0] dt_ff;
   logic [29:0] qa_ff;
   logic [63:0] five_dt_ff;
   logic        use_div_ff;
   logic [31:0] q0_ff;
   logic [2:0]  r0_ff;
   logic [63:0] rdt_ff;

   // kept state
   logic [31:0] rpm_ff;
   logic [31:0] last_count_ff;
   logic [63:0] last_time_ff;
   logic [1:0]  dir_ff;

   // output register
   logic        rsp_valid_ff;
   logic [15:0] rsp_speed_ff;
   logic [1:0]  rsp_dir_ff;
   logic        rsp_recomp_ff;

   logic        accept;
   logic        finish_go;
   logic        enough_revs;
   logic [31:0] limit;
   logic [58:0] a_in;
   logic [63:0] qa_prod;
   logic [2:0]  ra;
   logic [1:0]  carry;
   logic [2:0]  r0_in;
   logic [31:0] q0_in;
   logic [63:0] rdt_in;
   logic [32:0] sum;
   logic [31:0] rpm_sum;
   logic [1:0]  dir_in;

   sre_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .numerator (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo)
   );

   // datapath terms
   always_comb begin
      enough_revs = delta_ff >= {24'd0, cfg.min_revolutions};
      if (rpm_ff >= {16'd0, cfg.fast_band_rpm}) begin
         limit = cfg.fast_timeout_us;
      end else if (rpm_ff >= {16'd0, cfg.mid_band_rpm}) begin
         limit = cfg.mid_timeout_us;
      end else begin
         limit = cfg.slow_timeout_us;
      end
      a_in    = {27'd0, delta_ff} * {32'd0, SCALE_NUM};
      qa_prod = {32'd0, rpm_ff} * {32'd0, RECIP_FIVE};
      // rpm = 5*qa + ra, so 3*rpm = 15*qa + 3*ra; split 3*ra into 5*carry + r0
      ra = rpm_ff[2:0] - (qa_ff[2:0] + {qa_ff[0], 2'b00});
      case (ra)
         3'd0:    begin carry = 2'd0; r0_in = 3'd0; end
         3'd1:    begin carry = 2'd0; r0_in = 3'd3; end
         3'd2:    begin carry = 2'd1; r0_in = 3'd1; end
         3'd3:    begin carry = 2'd1; r0_in = 3'd4; end
         3'd4:    begin carry = 2'd2; r0_in = 3'd2; end
         default: begin carry = 2'd0; r0_in = 3'd0; end
      endcase
      q0_in  = {2'b00, qa_ff} + {1'b0, qa_ff, 1'b0} + {30'd0, carry};
      rdt_in = ({64{r0_ff[0]}} & dt_ff) + ({64{r0_ff[1]}} & {dt_ff[62:0], 1'b0})
             + ({64{r0_ff[2]}} & {dt_ff[61:0], 2'b00});
      sum    = {1'b0, q0_ff} + {1'b0, (use_div_ff ? div_quo[31:0] : 32'd0)};
      if ((use_div_ff && (div_quo[63:32] != 32'd0)) || sum[32]) begin
         rpm_sum = 32'hFFFF_FFFF;
      end else begin
         rpm_sum = sum[31:0];
      end
      if (rpm_ff > {16'd0, cfg.moving_rpm}) begin
         if (dir_ff == DIR_IDLE) begin
            dir_in = down_ff ? DIR_CCW : DIR_CW;
         end else begin
            dir_in = dir_ff;
         end
      end else begin
         dir_in = DIR_IDLE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req.valid) state_in = ST_CALC;
         ST_CALC:    state_in = enough_revs ? ST_SPLIT : ST_FINISH;
         ST_SPLIT:   state_in = ST_PREP;
         ST_PREP:    state_in = use_div_ff ? ST_LOAD_Q1 : ST_SUM;
         ST_LOAD_Q1: state_in = ST_WAIT_Q1;
         ST_WAIT_Q1: if (div_done) state_in = ST_SUM;
         ST_SUM:     state_in = ST_FINISH;
         ST_FINISH:  if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req.ready     = 1'b0;
      finish_go     = 1'b0;
      div_cmd.start = 1'b0;
      div_cmd.steps = Q1_STEPS;
      div_num       = '0;
      div_den       = '0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
         end
         ST_LOAD_Q1: begin
            // left-align the 62-bit numerator
            div_cmd.start = 1'b1;
            div_num       = {rdt_ff[61:0] + {3'd0, a_ff}, 2'b00};
            div_den       = five_dt_ff;
         end
         ST_FINISH: begin
            finish_go = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rpm_ff        <= '0;
         last_count_ff <= '0;
         last_time_ff  <= '0;
         dir_ff        <= DIR_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CALC && !enough_revs && elapsed_ff >= {32'd0, limit}) begin
            rpm_ff <= '0;
         end
         if (state_ff == ST_SUM) begin
            rpm_ff        <= rpm_sum;
            last_count_ff <= count_ff;
            last_time_ff  <= now_ff;
         end
         if (finish_go) begin
            dir_ff       <= dir_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         count_ff   <= req.revolution_count;
         now_ff     <= req.time_us;
         down_ff    <= req.counting_down;
         delta_ff   <= req.revolution_count - last_count_ff;
         elapsed_ff <= req.time_us - last_time_ff;
      end
      if (state_ff == ST_CALC) begin
         recomp_ff <= enough_revs;
         a_ff      <= a_in;
         dt_ff     <= (elapsed_ff == 64'd0) ? 64'd1 : elapsed_ff;
         qa_ff     <= qa_prod[63:34];
      end
      if (state_ff == ST_SPLIT) begin
         five_dt_ff <= dt_ff + {dt_ff[61:0], 2'b00};
         use_div_ff <= dt_ff <= {5'd0, a_ff};
         q0_ff      <= q0_in;
         r0_ff      <= r0_in;
      end
      if (state_ff == ST_PREP) begin
         rdt_ff <= rdt_in;
      end
      if (finish_go) begin
         rsp_speed_ff  <= (rpm_ff[31:16] != 16'd0) ? 16'hFFFF : rpm_ff[15:0];
         rsp_dir_ff    <= dir_in;
         rsp_recomp_ff <= recomp_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.speed_rpm      = rsp_speed_ff;
   assign rsp.turn_direction = rsp_dir_ff;
   assign rsp.recomputed     = rsp_recomp_ff;

endmodule

`default_nettype wire

/* rtl/core/sre_csr.sv */
`default_nettype none

module sre_csr import sre_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_MIN_REVOLUTIONS: cfg_in.min_revolutions = csr_write_data[7:0];
            REG_FAST_BAND_RPM:   cfg_in.fast_band_rpm   = csr_write_data[15:0];
            REG_FAST_TIMEOUT_US: cfg_in.fast_timeout_us = csr_write_data;
            REG_MID_BAND_RPM:    cfg_in.mid_band_rpm    = csr_write_data[15:0];
            REG_MID_TIMEOUT_US:  cfg_in.mid_timeout_us  = csr_write_data;
            REG_SLOW_TIMEOUT_US: cfg_in.slow_timeout_us = csr_write_data;
            REG_MOVING_RPM:      cfg_in.moving_rpm      = csr_write_data[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_revolutions <= RST_MIN_REVOLUTIONS;
         cfg_ff.fast_band_rpm   <= RST_FAST_BAND_RPM;
         cfg_ff.fast_timeout_us <= RST_FAST_TIMEOUT_US;
         cfg_ff.mid_band_rpm    <= RST_MID_BAND_RPM;
         cfg_ff.mid_timeout_us  <= RST_MID_TIMEOUT_US;
         cfg_ff.slow_timeout_us <= RST_SLOW_TIMEOUT_US;
         cfg_ff.moving_rpm      <= RST_MOVING_RPM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/core/sre_div.sv */
`default_nettype none

// Restoring divider, one quotient bit a cycle, numerator taken MSB first.
module sre_div import sre_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  div_cmd_type          cmd,
   input  logic [DIV_WIDTH-1:0] numerator,
   input  logic [DIV_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [DIV_WIDTH-1:0] quotient
);

   logic                      busy_ff;
   logic                      done_ff;
   logic [DIV_STEP_WIDTH-1:0] count_ff;
   logic [DIV_WIDTH-1:0]      num_ff;
   logic [DIV_WIDTH-1:0]      div_ff;
   logic [DIV_WIDTH-1:0]      rem_ff;
   logic [DIV_WIDTH-1:0]      quo_ff;

   logic [DIV_WIDTH:0] trial;
   logic [DIV_WIDTH:0] diff;
   logic               fits;

   always_comb begin
      trial = {rem_ff, num_ff[DIV_WIDTH-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff  <= 1'b1;
            count_ff <= cmd.steps;
         end else if (busy_ff) begin
            count_ff <= count_ff - DIV_STEP_WIDTH'(1);
            if (count_ff == DIV_STEP_WIDTH'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         num_ff <= numerator;
         div_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         // keep the partial remainder below the divisor
         rem_ff <= fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         quo_ff <= {quo_ff[DIV_WIDTH-2:0], fits};
         num_ff <= {num_ff[DIV_WIDTH-2:0], 1'b0};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* test/spindle_rpm_estimator_unit_check.sv */
`default_nettype none

module spindle_rpm_estimator_unit_check import sre_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   sre_req_if                         req,
   sre_rsp_if                         rsp,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int unsigned                mismatches,
   output int unsigned                readings_waiting,
   output int unsigned                readings_checked
);

   typedef struct packed {
      logic [15:0] speed_rpm;
      logic [1:0]  turn_direction;
      logic        recomputed;
   } reading_type;

   cfg_type     settings;
   logic [31:0] rpm_acc;
   logic [31:0] stored_count;
   logic [63:0] stored_time;
   logic [1:0]  heading;
   reading_type expected_readings[$];
   int unsigned fail_count = 0;
   int unsigned done_count = 0;

   // 0.6 * old + 0.4 * instantaneous, done exactly in wide integers
   function automatic logic [31:0] blend_rpm(input logic [31:0] rpm, input logic [31:0] delta,
                                             input logic [63:0] dt);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      num = 128'(rpm) * 128'd3 * 128'(dt) + 128'(delta) * 128'(SCALE_NUM);
      den = 128'(dt) * 128'd5;
      quo = num / den;
      return (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
   endfunction

   task automatic predict_update(input logic [31:0] count, input logic [63:0] now,
                                 input logic down, output reading_type r);
      logic [31:0] delta;
      logic [31:0] limit;
      logic [63:0] elapsed;
      delta        = count - stored_count;
      elapsed      = now - stored_time;
      r.recomputed = 1'b0;
      if (delta >= 32'(settings.min_revolutions)) begin
         rpm_acc      = blend_rpm(rpm_acc, delta, (elapsed == 64'd0) ? 64'd1 : elapsed);
         stored_count = count;
         stored_time  = now;
         r.recomputed = 1'b1;
      end else begin
         if (rpm_acc >= 32'(settings.fast_band_rpm)) begin
            limit = settings.fast_timeout_us;
         end else if (rpm_acc >= 32'(settings.mid_band_rpm)) begin
            limit = settings.mid_timeout_us;
         end else begin
            limit = settings.slow_timeout_us;
         end
         if (elapsed >= 64'(limit)) rpm_acc = '0;
      end
      // keep the latched direction while moving, whatever the bit does now
      if (rpm_acc > 32'(settings.moving_rpm)) begin
         if (heading == DIR_IDLE) heading = down ? DIR_CCW : DIR_CW;
      end else begin
         heading = DIR_IDLE;
      end
      r.speed_rpm      = (rpm_acc > 32'h0000_FFFF) ? 16'hFFFF : rpm_acc[15:0];
      r.turn_direction = heading;
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         settings.min_revolutions = RST_MIN_REVOLUTIONS;
         settings.fast_band_rpm   = RST_FAST_BAND_RPM;
         settings.fast_timeout_us = RST_FAST_TIMEOUT_US;
         settings.mid_band_rpm    = RST_MID_BAND_RPM;
         settings.mid_timeout_us  = RST_MID_TIMEOUT_US;
         settings.slow_timeout_us = RST_SLOW_TIMEOUT_US;
         settings.moving_rpm      = RST_MOVING_RPM;
         rpm_acc      = '0;
         stored_count = '0;
         stored_time  = '0;
         heading      = DIR_IDLE;
         expected_readings.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_readings.size() == 0) begin
               $error("result with nothing expected: speed_rpm %0d turn_direction %0d",
                      rsp.speed_rpm, rsp.turn_direction);
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               done_count++;
               if (rsp.speed_rpm !== want.speed_rpm) begin
                  $error("speed_rpm: expected %0d, got %0d", want.speed_rpm, rsp.speed_rpm);
                  fail_count++;
               end
               if (rsp.turn_direction !== want.turn_direction) begin
                  $error("turn_direction: expected %0d, got %0d",
                         want.turn_direction, rsp.turn_direction);
                  fail_count++;
               end
               if (rsp.recomputed !== want.recomputed) begin
                  $error("recomputed: expected %0d, got %0d", want.recomputed, rsp.recomputed);
                  fail_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_MIN_REVOLUTIONS: settings.min_revolutions = csr_write_data[7:0];
               REG_FAST_BAND_RPM:   settings.fast_band_rpm   = csr_write_data[15:0];
               REG_FAST_TIMEOUT_US: settings.fast_timeout_us = csr_write_data;
               REG_MID_BAND_RPM:    settings.mid_band_rpm    = csr_write_data[15:0];
               REG_MID_TIMEOUT_US:  settings.mid_timeout_us  = csr_write_data;
               REG_SLOW_TIMEOUT_US: settings.slow_timeout_us = csr_write_data;
               REG_MOVING_RPM:      settings.moving_rpm      = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            predict_update(req.revolution_count, req.time_us, req.counting_down, want);
            expected_readings.push_back(want);
         end
      end
      mismatches       <= fail_count;
      readings_waiting <= expected_readings.size();
      readings_checked <= done_count;
   end

endmodule

`default_nettype wire

/* test/spindle_rpm_estimator_unit_tb.sv */
`default_nettype none

module spindle_rpm_estimator_unit_tb;
   import sre_pkg::*;

   // index past the end of the register list
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;

   int unsigned mismatches;
   int unsigned readings_waiting;
   int unsigned readings_checked;

   logic [31:0] spin_count    = '0;
   logic [63:0] clock_us      = '0;
   logic        turn_down     = 1'b0;
   logic        calm          = 1'b0;
   int unsigned min_revs_now  = 4;
   int unsigned updates_sent  = 0;
   int unsigned settings_used = 0;
   int unsigned hold_left     = 0;

   sre_req_if req_ch ();
   sre_rsp_if rsp_ch ();

   spindle_rpm_estimator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   spindle_rpm_estimator_unit_check checker_i (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .readings_waiting (readings_waiting),
      .readings_checked (readings_checked)
   );

   always #2 clock = ~clock;

   // result side: stall in random bursts
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(0, 12);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_update(input logic [31:0] count, input logic [63:0] now,
                              input logic down);
      int unsigned gap;
      gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.revolution_count <= count;
      req_ch.time_us          <= now;
      req_ch.counting_down    <= down;
      do @(posedge clock); while (!req_ch.ready);
      updates_sent++;
   endtask

   // advance the spindle by some revolutions over some microseconds
   task automatic spin(input logic [31:0] revs, input logic [63:0] gap_us, input logic down);
      spin_count = spin_count + revs;
      clock_us   = clock_us + gap_us;
      send_update(spin_count, clock_us, down);
   endtask

   task automatic settle;
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (readings_waiting != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic random_run(input int unsigned n);
      int unsigned pick;
      int unsigned goal;
      logic [31:0] revs;
      logic [63:0] gap_us;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 7) == 0) turn_down = ~turn_down;
         if (pick < 8) begin
            // arbitrary count and time
            spin_count = $urandom;
            clock_us   = {$urandom, $urandom};
            send_update(spin_count, clock_us, turn_down);
         end else if (pick < 32) begin
            // too few revolutions: probe the stall timeouts
            revs = (min_revs_now == 0) ? 32'd0 : 32'($urandom_range(0, min_revs_now - 1));
            case ($urandom_range(0, 2))
               0:       gap_us = 64'($urandom_range(0, 100000));
               1:       gap_us = 64'($urandom_range(0, 6000000));
               default: gap_us = 64'($urandom);
            endcase
            spin(revs, gap_us, turn_down);
         end else begin
            revs = 32'(min_revs_now + $urandom_range(0, 20));
            case ($urandom_range(0, 3))
               0:       goal = $urandom_range(1, 150);
               1:       goal = $urandom_range(150, 1200);
               default: goal = $urandom_range(1200, 90000);
            endcase
            gap_us = 64'(revs) * 64'd60000000 / 64'(goal) + 64'($urandom_range(0, 50));
            if ($urandom_range(0, 19) == 0) gap_us = '0;
            spin(revs, gap_us, turn_down);
         end
      end
   endtask

   initial begin
      req_ch.valid            = 1'b0;
      req_ch.revolution_count = '0;
      req_ch.time_us          = '0;
      req_ch.counting_down    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset settings
      settings_used++;
      send_update(32'd0, 64'd0, 1'b0);
      send_update(32'd4, 64'd0, 1'b1);               // zero elapsed time
      send_update(32'd4, 64'd10, 1'b0);              // bit flips while moving
      send_update(32'd4, 64'd500000, 1'b0);          // fast band timeout, exactly
      send_update(32'hFFFF_FFFF, 64'd500001, 1'b0);  // count wrap, estimate saturates
      send_update(32'd3, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1);
      send_update(32'd7, 64'h10, 1'b1);              // time wrap
      spin_count = 32'd7;
      clock_us   = 64'h10;
      repeat (5) spin(32'd4, 64'd240000, 1'b1);      // steady 1000 rpm
      repeat (4) spin(32'd4, 64'd800000, 1'b0);      // settle into the middle band
      spin(32'd0, 64'd1900000, 1'b0);
      spin(32'd0, 64'd200000, 1'b0);                 // middle band timeout
      repeat (3) spin(32'd4, 64'd2400000, 1'b0);     // 100 rpm
      spin(32'd0, 64'd5000000, 1'b0);                // slow band timeout
      spin_count = 32'hFFFF_FFFF;
      clock_us   = 64'hFFFF_FFFF_FFFF_FFFF;
      send_update(spin_count, clock_us, 1'b1);
      random_run(100);

      // every update recomputes, zero fast and slow timeouts, masked writes
      settle;
      write_reg(REG_MIN_REVOLUTIONS, 32'h0000_1300);
      write_reg(REG_FAST_BAND_RPM, 32'h0001_FFFF);
      write_reg(REG_FAST_TIMEOUT_US, 32'd0);
      write_reg(REG_MID_BAND_RPM, 32'd300);
      write_reg(REG_MID_TIMEOUT_US, 32'hFFFF_FFFF);
      write_reg(REG_SLOW_TIMEOUT_US, 32'd0);
      write_reg(REG_MOVING_RPM, 32'h5A5A_0000);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      csr_write_enable <= 1'b0;
      min_revs_now = 0;
      settings_used++;
      random_run(110);

      settle;
      write_reg(REG_MIN_REVOLUTIONS, 32'd255);
      write_reg(REG_FAST_BAND_RPM, 32'd0);
      write_reg(REG_FAST_TIMEOUT_US, 32'hFFFF_FFFF);
      write_reg(REG_MID_BAND_RPM, 32'd65535);
      write_reg(REG_MID_TIMEOUT_US, 32'd0);
      write_reg(REG_SLOW_TIMEOUT_US, 32'd1000);
      write_reg(REG_MOVING_RPM, 32'd65535);
      csr_write_enable <= 1'b0;
      min_revs_now = 255;
      settings_used++;
      random_run(110);

      settle;
      write_reg(REG_MIN_REVOLUTIONS, 32'd1);
      write_reg(REG_FAST_BAND_RPM, 32'd5000);
      write_reg(REG_FAST_TIMEOUT_US, 32'd30000);
      write_reg(REG_MID_BAND_RPM, 32'd0);
      write_reg(REG_MID_TIMEOUT_US, 32'd400000);
      write_reg(REG_SLOW_TIMEOUT_US, 32'hFFFF_FFFF);
      write_reg(REG_MOVING_RPM, 32'd1);
      csr_write_enable <= 1'b0;
      min_revs_now = 1;
      settings_used++;
      random_run(110);

      // random settings; no idling from here on
      settle;
      min_revs_now = $urandom_range(1, 16);
      write_reg(REG_MIN_REVOLUTIONS, 32'(min_revs_now));
      write_reg(REG_FAST_BAND_RPM, 32'($urandom_range(600, 65535)));
      write_reg(REG_FAST_TIMEOUT_US, 32'($urandom_range(0, 3000000)));
      write_reg(REG_MID_BAND_RPM, 32'($urandom_range(0, 600)));
      write_reg(REG_MID_TIMEOUT_US, 32'($urandom_range(0, 6000000)));
      write_reg(REG_SLOW_TIMEOUT_US, $urandom);
      write_reg(REG_MOVING_RPM, 32'($urandom_range(0, 2000)));
      csr_write_enable <= 1'b0;
      calm <= 1'b1;
      settings_used++;
      random_run(110);

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (readings_waiting != 0);
      repeat (150) @(posedge clock);
      $display("Sent %0d speed updates across %0d register settings; %0d results compared.",
               updates_sent, settings_used, readings_checked);
      if (mismatches == 0 && readings_waiting == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Run did not complete in time.");
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/core/sre_pkg.sv
rtl/core/sre_if.sv
rtl/core/sre_csr.sv
rtl/core/sre_div.sv
rtl/core/spindle_rpm_estimator_unit.sv
test/spindle_rpm_estimator_unit_check.sv
test/spindle_rpm_estimator_unit_tb.sv
